[sv/lrsa_pkg.sv]
// Package with the shared widths, codes, types and helpers of the log-rank accumulator.
package lrsa_pkg;

  localparam int unsigned CNT_W         = 13;
  localparam int unsigned SUM_W         = 30;
  localparam int unsigned MAX_ITEMS     = 4096;
  localparam int unsigned FRAC_BITS_DEF = 16;

  localparam logic REG_TOTAL_COUNT = 1'b0;
  localparam logic REG_ONES_COUNT  = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_TERM,
    ST_ACC,
    ST_UPD,
    ST_EMIT
  } lrsa_state_e;

  typedef struct packed {
    logic load_item;
    logic div_step;
    logic term_calc;
    logic acc_sum;
    logic upd_cnt;
    logic emit;
  } lrsa_cmd_t;

  typedef struct packed {
    logic need_div;
    logic div_last;
    logic is_last;
    logic pop_zero;
  } lrsa_sts_t;

  // Counters reload from a register value limited to the largest run length.
  function automatic logic [CNT_W-1:0] cap_load(input logic [CNT_W-1:0] v);
    logic [CNT_W-1:0] c;
    c = v;
    if (32'(v) > 32'(MAX_ITEMS)) begin
      c = CNT_W'(MAX_ITEMS);
    end
    return c;
  endfunction

endpackage

[sv/logrank_statistic_accumulator_core.sv]
// Top level of the two-group log-rank statistic accumulator.
// Each transfer on the input channel is one subject in time order. An item with
// an event bit and valid counts passes through the restoring divider, which forms
// one quotient bit of the expected share per cycle over FRAC_BITS + 13 steps,
// then the term and sum steps before the next item can be taken; any other item
// only updates the counts. The last item of a run then loads the result register,
// and waits there only while an earlier result is still untaken. Register writes
// also reload the matching counter at once.
module logrank_statistic_accumulator_core import lrsa_pkg::*; #(
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic                    cfg_index_i,
  input  logic [CNT_W-1:0]        cfg_data_i,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic                    in_group_i,
  input  logic                    event_flag_i,
  input  logic                    last_item_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic signed [SUM_W-1:0] stat_value_o,
  output logic                    count_error_o
);

  lrsa_cmd_t cmd;
  lrsa_sts_t sts;

  lrsa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  lrsa_datapath #(
    .FRAC_BITS (FRAC_BITS)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_group_i    (in_group_i),
    .event_flag_i  (event_flag_i),
    .last_item_i   (last_item_i),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .stat_value_o  (stat_value_o),
    .count_error_o (count_error_o)
  );

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("input taken again right after a transfer");

  a_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.div_step |-> !sts.pop_zero)
    else $error("division runs with a zero population");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit |-> (!out_valid_o || out_ready_i))
    else $error("result register loaded while a result is pending");

  a_valid_from_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(cmd.emit))
    else $error("result shown without a load");
`endif

endmodule

[sv/lrsa_ctrl.sv]
// Controller state machine that sequences one item through the datapath.
module lrsa_ctrl import lrsa_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  input  lrsa_sts_t sts_i,
  output lrsa_cmd_t cmd_o
);

  lrsa_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;
  logic        slot_free;

  assign slot_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_item = 1'b1;
          state_d = sts_i.need_div ? ST_DIV : ST_UPD;
        end
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) begin
          state_d = ST_TERM;
        end
      end
      ST_TERM: begin
        cmd_o.term_calc = 1'b1;
        state_d = ST_ACC;
      end
      ST_ACC: begin
        cmd_o.acc_sum = 1'b1;
        cmd_o.upd_cnt = 1'b1;
        state_d = sts_i.is_last ? ST_EMIT : ST_IDLE;
      end
      ST_UPD: begin
        cmd_o.upd_cnt = 1'b1;
        state_d = sts_i.is_last ? ST_EMIT : ST_IDLE;
      end
      ST_EMIT: begin
        if (slot_free) begin
          cmd_o.emit = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

[sv/lrsa_datapath.sv]
// Datapath with counters, restoring divider, saturating sum and result register.
module lrsa_datapath import lrsa_pkg::*; #(
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic                    cfg_index_i,
  input  logic [CNT_W-1:0]        cfg_data_i,
  input  logic                    in_group_i,
  input  logic                    event_flag_i,
  input  logic                    last_item_i,
  input  lrsa_cmd_t               cmd_i,
  output lrsa_sts_t               sts_o,
  output logic signed [SUM_W-1:0] stat_value_o,
  output logic                    count_error_o
);

  localparam int unsigned QW = CNT_W + FRAC_BITS;
  localparam int unsigned TW = QW + 1;
  localparam int unsigned AW = ((TW > SUM_W) ? TW : SUM_W) + 1;
  localparam int unsigned SW = $clog2(QW + 1);

  logic [CNT_W-1:0]        total_q, ones_cfg_q;
  logic [CNT_W-1:0]        ones_left_q, pop_left_q;
  logic signed [SUM_W-1:0] sum_q, sum_d;
  logic                    err_q;
  logic                    grp_q, last_q;
  logic [CNT_W-1:0]        rem_q;
  logic [QW-1:0]           quo_q;
  logic [SW-1:0]           cnt_q;
  logic signed [TW-1:0]    term_q;
  logic signed [SUM_W-1:0] stat_q;
  logic                    cerr_q;

  logic                    pop_zero, ones_zero, bad;
  logic [CNT_W:0]          shifted;
  logic                    q_bit;
  logic [TW-1:0]           grp_ext;
  logic signed [AW-1:0]    sum_wide;
  logic                    ovf;

  assign pop_zero  = (pop_left_q == '0);
  assign ones_zero = (ones_left_q == '0);
  assign bad       = pop_zero || (grp_q && ones_zero);

  assign sts_o.need_div = event_flag_i && !pop_zero && !(in_group_i && ones_zero);
  assign sts_o.div_last = (cnt_q == SW'(1));
  assign sts_o.is_last  = last_q;
  assign sts_o.pop_zero = pop_zero;

  // One quotient bit per cycle of the restoring division.
  assign shifted = {rem_q, quo_q[QW-1]};
  assign q_bit   = (shifted >= {1'b0, pop_left_q});

  assign grp_ext = TW'(grp_q) << FRAC_BITS;

  assign sum_wide = {{(AW-SUM_W){sum_q[SUM_W-1]}}, sum_q} +
                    {{(AW-TW){term_q[TW-1]}}, term_q};
  assign ovf = !((&sum_wide[AW-1:SUM_W-1]) || !(|sum_wide[AW-1:SUM_W-1]));

  always_comb begin
    if (!ovf) begin
      sum_d = sum_wide[SUM_W-1:0];
    end else if (sum_wide[AW-1]) begin
      sum_d = {1'b1, {(SUM_W-1){1'b0}}};
    end else begin
      sum_d = {1'b0, {(SUM_W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q     <= CNT_W'(1);
      ones_cfg_q  <= '0;
      pop_left_q  <= CNT_W'(1);
      ones_left_q <= '0;
      sum_q       <= '0;
      err_q       <= 1'b0;
      cnt_q       <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          REG_TOTAL_COUNT: begin
            total_q    <= cfg_data_i;
            pop_left_q <= cap_load(cfg_data_i);
          end
          REG_ONES_COUNT: begin
            ones_cfg_q  <= cfg_data_i;
            ones_left_q <= cap_load(cfg_data_i);
          end
          default: begin
          end
        endcase
      end
      if (cmd_i.load_item) begin
        cnt_q <= SW'(QW);
      end else if (cmd_i.div_step) begin
        cnt_q <= cnt_q - SW'(1);
      end
      if (cmd_i.acc_sum) begin
        sum_q <= sum_d;
      end
      if (cmd_i.upd_cnt) begin
        err_q <= err_q | bad;
        if (!pop_zero) begin
          pop_left_q <= pop_left_q - CNT_W'(1);
          if (grp_q && !ones_zero) begin
            ones_left_q <= ones_left_q - CNT_W'(1);
          end
        end
      end
      if (cmd_i.emit) begin
        pop_left_q  <= cap_load(total_q);
        ones_left_q <= cap_load(ones_cfg_q);
        sum_q       <= '0;
        err_q       <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      grp_q  <= in_group_i;
      last_q <= last_item_i;
      rem_q  <= '0;
      quo_q  <= {ones_left_q, {FRAC_BITS{1'b0}}};
    end else if (cmd_i.div_step) begin
      rem_q <= q_bit ? CNT_W'(shifted - {1'b0, pop_left_q}) : shifted[CNT_W-1:0];
      quo_q <= {quo_q[QW-2:0], q_bit};
    end
    if (cmd_i.term_calc) begin
      term_q <= grp_ext - {1'b0, quo_q};
    end
    if (cmd_i.emit) begin
      stat_q <= sum_q;
      cerr_q <= err_q;
    end
  end

  assign stat_value_o  = stat_q;
  assign count_error_o = cerr_q;

endmodule

[dv/logrank_statistic_accumulator_core_test.sv]
// Self-checking testbench for the log-rank statistic accumulator core.
module logrank_statistic_accumulator_core_test;
  import lrsa_pkg::*;

  localparam int unsigned FRAC = FRAC_BITS_DEF;
  localparam int unsigned SETTLE_CYCLES = FRAC + 24;
  localparam longint CYCLE_LIMIT = 2000000;
  localparam longint SUM_HI = (longint'(1) << (SUM_W - 1)) - 1;
  localparam longint SUM_LO = -(longint'(1) << (SUM_W - 1));

  typedef struct packed {
    logic grp;
    logic evt;
    logic last;
  } subject_t;

  typedef struct packed {
    logic signed [SUM_W-1:0] stat;
    logic                    err;
  } run_result_t;

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    cfg_we_i = 1'b0;
  logic                    cfg_index_i = REG_TOTAL_COUNT;
  logic [CNT_W-1:0]        cfg_data_i = '0;
  logic                    in_valid_i = 1'b0;
  logic                    in_ready_o;
  logic                    in_group_i = 1'b0;
  logic                    event_flag_i = 1'b0;
  logic                    last_item_i = 1'b0;
  logic                    out_valid_o;
  logic                    out_ready_i = 1'b0;
  logic signed [SUM_W-1:0] stat_value_o;
  logic                    count_error_o;

  logic [CNT_W-1:0] total_reg;
  logic [CNT_W-1:0] ones_reg;
  logic [CNT_W-1:0] ones_left;
  logic [CNT_W-1:0] pop_left;
  longint           run_sum;
  bit               err_seen;

  subject_t    pending_subjects[$];
  run_result_t run_results_due[$];

  int unsigned sender_idle_pct = 21;
  int unsigned receiver_idle_pct = 86;
  int unsigned subjects_queued = 0;
  int unsigned subjects_taken = 0;
  int unsigned results_checked = 0;
  int unsigned flagged_results = 0;
  int unsigned settings_done = 0;
  int unsigned mismatches = 0;
  longint      cycles = 0;

  logrank_statistic_accumulator_core #(
    .FRAC_BITS(FRAC)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_group_i   (in_group_i),
    .event_flag_i (event_flag_i),
    .last_item_i  (last_item_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .stat_value_o (stat_value_o),
    .count_error_o(count_error_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic logic [CNT_W-1:0] clamp_count(logic [CNT_W-1:0] v);
    return (v > CNT_W'(MAX_ITEMS)) ? CNT_W'(MAX_ITEMS) : v;
  endfunction

  function automatic void restart_run();
    ones_left = clamp_count(ones_reg);
    pop_left  = clamp_count(total_reg);
    run_sum   = 0;
    err_seen  = 1'b0;
  endfunction

  function automatic void predict_subject(subject_t s);
    longint share;
    longint term;
    bit     bad;
    bad  = 1'b0;
    term = 0;
    if (pop_left == '0) begin
      bad = 1'b1;
    end else begin
      share = (longint'(ones_left) << FRAC) / longint'(pop_left);
      if (s.grp && ones_left == '0) begin
        bad = 1'b1;
      end else begin
        term = (s.grp ? (longint'(1) << FRAC) : longint'(0)) - share;
        if (s.grp) begin
          ones_left = ones_left - CNT_W'(1);
        end
      end
      pop_left = pop_left - CNT_W'(1);
    end
    if (bad) begin
      err_seen = 1'b1;
      term     = 0;
    end
    if (s.evt) begin
      run_sum = run_sum + term;
      if (run_sum > SUM_HI) begin
        run_sum = SUM_HI;
      end
      if (run_sum < SUM_LO) begin
        run_sum = SUM_LO;
      end
    end
    if (s.last) begin
      run_results_due.push_back('{stat: run_sum[SUM_W-1:0], err: err_seen});
      restart_run();
    end
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("MISMATCH at cycle %0d: %s, got %0d, expected %0d", cycles, what, got, want);
    mismatches++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i   <= 1'b0;
      in_group_i   <= 1'b0;
      event_flag_i <= 1'b0;
      last_item_i  <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        predict_subject('{grp: in_group_i, evt: event_flag_i, last: last_item_i});
        subjects_taken++;
      end
      if (!in_valid_i || in_ready_o) begin
        if (pending_subjects.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
          subject_t s;
          s = pending_subjects.pop_front();
          in_valid_i   <= 1'b1;
          in_group_i   <= s.grp;
          event_flag_i <= s.evt;
          last_item_i  <= s.last;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (run_results_due.size() == 0) begin
          report_mismatch("run result with none expected", longint'(stat_value_o), 0);
        end else begin
          run_result_t want;
          want = run_results_due.pop_front();
          if (stat_value_o !== want.stat) begin
            report_mismatch("stat_value", longint'(stat_value_o), longint'(want.stat));
          end
          if (count_error_o !== want.err) begin
            report_mismatch("count_error", longint'(count_error_o), longint'(want.err));
          end
          results_checked++;
          if (want.err) begin
            flagged_results++;
          end
        end
      end
      out_ready_i <= ($urandom_range(99) >= receiver_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timed out with %0d run results outstanding.", run_results_due.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic cfg_write(logic idx, logic [CNT_W-1:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    if (idx == REG_TOTAL_COUNT) begin
      total_reg = val;
      pop_left  = clamp_count(val);
    end else begin
      ones_reg  = val;
      ones_left = clamp_count(val);
    end
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic push_subject(logic grp, logic evt, logic last);
    pending_subjects.push_back('{grp: grp, evt: evt, last: last});
    subjects_queued++;
  endtask

  task automatic settle_block();
    while (subjects_taken != subjects_queued || run_results_due.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // A tidy run draws group bits so that the ones count is used up exactly when it does not exceed the run length.
  task automatic queue_run(int unsigned len, bit tidy);
    int unsigned r_pop;
    int unsigned r_ones;
    int unsigned evt_pct;
    int unsigned k;
    logic        grp;
    r_pop   = len;
    r_ones  = 32'(clamp_count(ones_reg));
    evt_pct = $urandom_range(100, 30);
    for (k = 0; k < len; k++) begin
      if (tidy) begin
        grp = ($urandom_range(r_pop - 1) < r_ones);
      end else begin
        grp = 1'($urandom_range(1));
      end
      if (grp && r_ones > 0) begin
        r_ones--;
      end
      r_pop--;
      push_subject(grp, $urandom_range(99) < evt_pct, k == len - 1);
    end
  endtask

  task automatic random_phase(int unsigned target);
    int unsigned queued;
    int unsigned total_v;
    int unsigned ones_v;
    int unsigned cap;
    int unsigned len;
    int unsigned r;
    bit          tidy;
    queued = 0;
    while (queued < target) begin
      r = $urandom_range(99);
      if (r < 65) begin
        total_v = $urandom_range(16, 1);
      end else if (r < 80) begin
        total_v = $urandom_range(64, 17);
      end else if (r < 88) begin
        total_v = $urandom_range(8191, 0);
      end else if (r < 95) begin
        total_v = $urandom_range(8191, 4096);
      end else begin
        total_v = $urandom_range(1, 0);
      end
      cap = 32'(clamp_count(CNT_W'(total_v)));
      r = $urandom_range(99);
      if (r < 70) begin
        ones_v = $urandom_range(cap, 0);
      end else if (r < 80) begin
        ones_v = 0;
      end else if (r < 90) begin
        ones_v = cap + $urandom_range(8, 1);
      end else begin
        ones_v = $urandom_range(8191, 0);
      end
      r = $urandom_range(9);
      if (r != 0) begin
        cfg_write(REG_TOTAL_COUNT, CNT_W'(total_v));
      end
      if (r != 1) begin
        cfg_write(REG_ONES_COUNT, CNT_W'(ones_v));
      end
      cap = 32'(clamp_count(total_reg));
      repeat ($urandom_range(4, 1)) begin
        tidy = ($urandom_range(99) < 80);
        if (tidy && cap >= 1 && cap <= 64) begin
          len = cap;
        end else begin
          len = $urandom_range(((cap > 60) ? 60 : cap) + 4, 1);
        end
        queue_run(len, tidy);
        queued += len;
      end
      settings_done++;
      settle_block();
    end
  endtask

  initial begin
    total_reg = CNT_W'(1);
    ones_reg  = '0;
    restart_run();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Out of reset: one subject against a population of one with no ones.
    push_subject(1'b0, 1'b1, 1'b1);
    settle_block();

    // More ones than population drives the sum into negative saturation.
    cfg_write(REG_TOTAL_COUNT, 13'd4);
    cfg_write(REG_ONES_COUNT, 13'd4096);
    push_subject(1'b0, 1'b1, 1'b0);
    push_subject(1'b0, 1'b1, 1'b0);
    push_subject(1'b0, 1'b1, 1'b0);
    push_subject(1'b0, 1'b1, 1'b1);
    settle_block();

    // Register values above the largest run length are capped on load.
    cfg_write(REG_TOTAL_COUNT, '1);
    cfg_write(REG_ONES_COUNT, '1);
    push_subject(1'b1, 1'b1, 1'b0);
    push_subject(1'b0, 1'b0, 1'b0);
    push_subject(1'b1, 1'b1, 1'b1);
    settle_block();

    // An empty population flags the run from the first subject.
    cfg_write(REG_TOTAL_COUNT, '0);
    cfg_write(REG_ONES_COUNT, '0);
    push_subject(1'b0, 1'b1, 1'b1);
    settle_block();

    // With the ones count already at zero, the population runs out, with and without events.
    cfg_write(REG_TOTAL_COUNT, 13'd2);
    push_subject(1'b1, 1'b1, 1'b0);
    push_subject(1'b0, 1'b0, 1'b0);
    push_subject(1'b0, 1'b1, 1'b0);
    push_subject(1'b1, 1'b0, 1'b1);
    settle_block();

    cfg_write(REG_TOTAL_COUNT, 13'd3);
    cfg_write(REG_ONES_COUNT, 13'd1);
    push_subject(1'b1, 1'b1, 1'b0);
    push_subject(1'b0, 1'b1, 1'b0);
    push_subject(1'b0, 1'b1, 1'b1);
    settle_block();
    settings_done += 6;

    random_phase(580);
    sender_idle_pct   = 86;
    receiver_idle_pct = 21;
    random_phase(580);
    sender_idle_pct   = 0;
    receiver_idle_pct = 0;
    random_phase(580);

    $display("Covered %0d subject transfers over %0d register settings and three stall mixes.",
             subjects_taken, settings_done);
    $display("Compared %0d run results, %0d of them with the count error flag raised.",
             results_checked, flagged_results);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

[filelist.f]
sv/lrsa_pkg.sv
sv/lrsa_ctrl.sv
sv/lrsa_datapath.sv
sv/logrank_statistic_accumulator_core.sv
dv/logrank_statistic_accumulator_core_test.sv
